@@ sv/bom_sniffing_utf16_to_utf8_transcoder_macros.svh @@
// Assertion macros used by the checker file of the transcoder.
`ifndef BOM_SNIFFING_UTF16_TO_UTF8_TRANSCODER_MACROS_SVH
`define BOM_SNIFFING_UTF16_TO_UTF8_TRANSCODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define B16U8_ASSERT_IMPL(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("b16u8 same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define B16U8_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("b16u8 next-cycle check failed");

`endif

@@ sv/b16u8_pkg.sv @@
// Types and constants shared by the transcoder modules.
`timescale 1ns / 1ps
package b16u8_pkg;

  typedef enum logic [3:0] {
    ST_OK           = 4'd0,
    ST_UTF32        = 4'd1,
    ST_BAD_UTF8_BOM = 4'd2,
    ST_BAD_UTF8     = 4'd3,
    ST_ODD_UTF16    = 4'd4,
    ST_CUT_PAIR     = 4'd5,
    ST_BAD_PAIR     = 4'd6,
    ST_LONE_LOW     = 4'd7,
    ST_BAD_SCALAR   = 4'd8
  } status_e;

  typedef enum logic [1:0] {
    FMT_UTF8     = 2'd0,
    FMT_UTF8_BOM = 2'd1,
    FMT_UTF16LE  = 2'd2,
    FMT_UTF16BE  = 2'd3
  } fmt_e;

  typedef enum logic [1:0] {
    PH_DETECT = 2'd0,
    PH_UTF8   = 2'd1,
    PH_UTF16  = 2'd2,
    PH_DRAIN  = 2'd3
  } phase_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    status_e    status;
    fmt_e       detected_format;
    logic       run_last;
    logic       stream_done;
  } out_item_t;

  // One result as produced by the decoder, before its position in the run is known.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    status_e    status;
    fmt_e       detected_format;
    logic       stream_done;
  } res_t;

  localparam int unsigned MaxRes = 4;

  typedef struct packed {
    logic                   load;
    logic [2:0]             count;
    res_t [MaxRes-1:0]      items;
  } grp_t;

  // Lead byte classes of a multi-byte UTF-8 sequence.
  localparam logic [1:0] CLS_TWO   = 2'd0;
  localparam logic [1:0] CLS_THREE = 2'd1;
  localparam logic [1:0] CLS_FOUR  = 2'd2;

  localparam logic [3:0][20:0] CLASS_MIN = {21'h10000, 21'h10000, 21'h00800, 21'h00080};
  localparam logic [20:0] CP_MAX   = 21'h10FFFF;
  localparam logic [20:0] SURR_MIN = 21'h00D800;
  localparam logic [20:0] SURR_MAX = 21'h00DFFF;
  localparam logic [20:0] PLANE1   = 21'h010000;

  localparam logic [5:0] HI_SURR_TAG = 6'b110110;
  localparam logic [5:0] LO_SURR_TAG = 6'b110111;

  // Byte-order marks, first byte at index 0.
  localparam logic [3:0][7:0] MARK_UTF8   = {8'h00, 8'hBF, 8'hBB, 8'hEF};
  localparam logic [3:0][7:0] MARK_U16BE  = {8'h00, 8'h00, 8'hFF, 8'hFE};
  localparam logic [3:0][7:0] MARK_U32LE  = {8'h00, 8'h00, 8'hFE, 8'hFF};
  localparam logic [3:0][7:0] MARK_U32BE  = {8'hFF, 8'hFE, 8'h00, 8'h00};

endpackage

@@ sv/b16u8_core.sv @@
// Input register, stream state and single-pass decode of one byte into a result group.
`timescale 1ns / 1ps
module b16u8_core
  import b16u8_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_item_t in_item_i,
  output logic     in_stall_o,
  input  logic     free_i,
  output grp_t     grp_o
);

  typedef struct packed {
    phase_e          phase;
    logic [2:0][7:0] held;
    logic [1:0]      held_count;
    fmt_e            fmt;
    logic [1:0]      pend;
    logic [20:0]     partial;
    logic [1:0]      min_class;
    logic [7:0]      low_half;
    logic            half_flag;
    logic [9:0]      hs_bits;
    logic            hs_pend;
  } state_t;

  typedef struct packed {
    state_t            st;
    logic [2:0]        rn;
    res_t [MaxRes-1:0] r;
  } work_t;

  localparam state_t StateReset = '0;

  function automatic work_t f_push(work_t w, logic [7:0] b, logic v, status_e s, logic done);
    work_t o;
    o = w;
    if (w.rn != 3'(MaxRes)) begin
      o.r[w.rn[1:0]] = '{out_byte: b, byte_valid: v, status: s,
                         detected_format: w.st.fmt, stream_done: done};
      o.rn = w.rn + 3'd1;
    end
    return o;
  endfunction

  function automatic work_t f_error(work_t w, status_e s);
    work_t o;
    o = f_push(w, 8'h00, 1'b0, s, 1'b1);
    o.st.phase = PH_DRAIN;
    return o;
  endfunction

  function automatic work_t f_utf8_err(work_t w);
    work_t o;
    if (w.st.fmt == FMT_UTF8_BOM) begin
      o = f_error(w, ST_BAD_UTF8_BOM);
    end else begin
      o = f_error(w, ST_BAD_UTF8);
    end
    return o;
  endfunction

  function automatic work_t f_utf8(work_t w, logic [7:0] b);
    work_t       o;
    logic [20:0] cp;
    o  = w;
    cp = {w.st.partial[14:0], b[5:0]};
    if (w.st.pend == 2'd0) begin
      if (b <= 8'h7F) begin
        o = f_push(w, b, 1'b1, ST_OK, 1'b0);
      end else if (b >= 8'hC2 && b <= 8'hDF) begin
        o.st.pend      = 2'd1;
        o.st.partial   = {16'h0, b[4:0]};
        o.st.min_class = CLS_TWO;
        o = f_push(o, b, 1'b1, ST_OK, 1'b0);
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
        o.st.pend      = 2'd2;
        o.st.partial   = {17'h0, b[3:0]};
        o.st.min_class = CLS_THREE;
        o = f_push(o, b, 1'b1, ST_OK, 1'b0);
      end else if (b >= 8'hF0 && b <= 8'hF4) begin
        o.st.pend      = 2'd3;
        o.st.partial   = {18'h0, b[2:0]};
        o.st.min_class = CLS_FOUR;
        o = f_push(o, b, 1'b1, ST_OK, 1'b0);
      end else begin
        o = f_utf8_err(w);
      end
    end else if (b[7:6] != 2'b10) begin
      o = f_utf8_err(w);
    end else begin
      o.st.partial = cp;
      o.st.pend    = w.st.pend - 2'd1;
      if (w.st.pend == 2'd1 &&
          (cp < CLASS_MIN[w.st.min_class] || cp > CP_MAX ||
           (cp >= SURR_MIN && cp <= SURR_MAX))) begin
        o = f_utf8_err(o);
      end else begin
        o = f_push(o, b, 1'b1, ST_OK, 1'b0);
      end
    end
    return o;
  endfunction

  function automatic work_t f_emit(work_t w, logic [20:0] cp);
    work_t o;
    o = w;
    if (cp <= 21'h7F) begin
      o = f_push(o, cp[7:0], 1'b1, ST_OK, 1'b0);
    end else if (cp <= 21'h7FF) begin
      o = f_push(o, {3'b110, cp[10:6]}, 1'b1, ST_OK, 1'b0);
      o = f_push(o, {2'b10, cp[5:0]}, 1'b1, ST_OK, 1'b0);
    end else if (cp <= 21'hFFFF) begin
      o = f_push(o, {4'b1110, cp[15:12]}, 1'b1, ST_OK, 1'b0);
      o = f_push(o, {2'b10, cp[11:6]}, 1'b1, ST_OK, 1'b0);
      o = f_push(o, {2'b10, cp[5:0]}, 1'b1, ST_OK, 1'b0);
    end else begin
      o = f_push(o, {5'b11110, cp[20:18]}, 1'b1, ST_OK, 1'b0);
      o = f_push(o, {2'b10, cp[17:12]}, 1'b1, ST_OK, 1'b0);
      o = f_push(o, {2'b10, cp[11:6]}, 1'b1, ST_OK, 1'b0);
      o = f_push(o, {2'b10, cp[5:0]}, 1'b1, ST_OK, 1'b0);
    end
    return o;
  endfunction

  function automatic work_t f_utf16(work_t w, logic [7:0] b);
    work_t       o;
    logic [15:0] unit;
    o    = w;
    unit = (w.st.fmt == FMT_UTF16LE) ? {b, w.st.low_half} : {w.st.low_half, b};
    if (!w.st.half_flag) begin
      o.st.low_half  = b;
      o.st.half_flag = 1'b1;
    end else begin
      o.st.half_flag = 1'b0;
      if (w.st.hs_pend) begin
        if (unit[15:10] != LO_SURR_TAG) begin
          o = f_error(o, ST_BAD_PAIR);
        end else begin
          o.st.hs_pend = 1'b0;
          o = f_emit(o, PLANE1 + {1'b0, w.st.hs_bits, unit[9:0]});
        end
      end else if (unit[15:10] == HI_SURR_TAG) begin
        o.st.hs_bits = unit[9:0];
        o.st.hs_pend = 1'b1;
      end else if (unit[15:10] == LO_SURR_TAG) begin
        o = f_error(o, ST_LONE_LOW);
      end else begin
        o = f_emit(o, {5'h00, unit});
      end
    end
    return o;
  endfunction

  function automatic work_t f_replay(work_t w, logic [3:0][7:0] p, logic [2:0] k);
    work_t o;
    o               = w;
    o.st.fmt        = FMT_UTF8;
    o.st.phase      = PH_UTF8;
    o.st.held_count = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < k && o.st.phase == PH_UTF8) begin
        o = f_utf8(o, p[i]);
      end
    end
    return o;
  endfunction

  function automatic logic f_pfx(logic [3:0][7:0] p, logic [2:0] k, logic [3:0][7:0] pat);
    logic m;
    m = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < k && p[i] != pat[i]) begin
        m = 1'b0;
      end
    end
    return m;
  endfunction

  function automatic work_t f_detect(work_t w, logic [7:0] b);
    work_t           o;
    logic [3:0][7:0] p;
    logic [2:0]      k;
    logic            hold;
    o    = w;
    p    = {8'h00, w.st.held};
    p[w.st.held_count] = b;
    k    = {1'b0, w.st.held_count} + 3'd1;
    hold = (k < 3'd3 && f_pfx(p, k, MARK_UTF8)) || (k < 3'd2 && f_pfx(p, k, MARK_U16BE)) ||
           (k < 3'd4 && f_pfx(p, k, MARK_U32LE)) || (k < 3'd4 && f_pfx(p, k, MARK_U32BE));
    if (k == 3'd3 && p[2:0] == MARK_UTF8[2:0]) begin
      o.st.fmt        = FMT_UTF8_BOM;
      o.st.phase      = PH_UTF8;
      o.st.held_count = 2'd0;
    end else if (k == 3'd2 && p[1:0] == MARK_U16BE[1:0]) begin
      o.st.fmt        = FMT_UTF16BE;
      o.st.phase      = PH_UTF16;
      o.st.held_count = 2'd0;
    end else if (k == 3'd4 && (p == MARK_U32LE || p == MARK_U32BE)) begin
      o.st.held_count = 2'd0;
      o = f_error(o, ST_UTF32);
    end else if (k >= 3'd3 && p[0] == 8'hFF && p[1] == 8'hFE && b != 8'h00) begin
      o.st.fmt        = FMT_UTF16LE;
      o.st.phase      = PH_UTF16;
      o.st.held_count = 2'd0;
      if (k == 3'd4) begin
        o = f_utf16(o, 8'h00);
      end
      o = f_utf16(o, b);
    end else if (hold) begin
      o.st.held       = p[2:0];
      o.st.held_count = k[1:0];
    end else begin
      o = f_replay(o, p, k);
    end
    return o;
  endfunction

  function automatic work_t f_finish(work_t w);
    work_t      o;
    logic [1:0] idx;
    o = w;
    if (o.st.phase == PH_DETECT) begin
      if (o.st.held_count >= 2'd2 && o.st.held[0] == 8'hFF && o.st.held[1] == 8'hFE) begin
        o.st.fmt   = FMT_UTF16LE;
        o.st.phase = PH_UTF16;
        if (o.st.held_count == 2'd3) begin
          o.st.low_half  = o.st.held[2];
          o.st.half_flag = 1'b1;
        end
        o.st.held_count = 2'd0;
      end else begin
        o = f_replay(o, {8'h00, o.st.held}, {1'b0, o.st.held_count});
      end
    end
    if (o.st.phase == PH_UTF8 && o.st.pend != 2'd0) begin
      o = f_utf8_err(o);
    end
    if (o.st.phase == PH_UTF16) begin
      if (o.st.half_flag) begin
        o = f_error(o, ST_ODD_UTF16);
      end else if (o.st.hs_pend) begin
        o = f_error(o, ST_CUT_PAIR);
      end
    end
    idx = 2'(o.rn - 3'd1);
    if (o.st.phase != PH_DRAIN) begin
      if (o.rn != 3'd0 && o.r[idx].byte_valid) begin
        o.r[idx].stream_done = 1'b1;
      end else begin
        o = f_push(o, 8'h00, 1'b0, ST_OK, 1'b1);
      end
    end
    return o;
  endfunction

  logic     in_valid_q, in_valid_d;
  in_item_t in_item_q;
  state_t   state_q, state_d;
  work_t    work;
  logic     accept;
  logic     consume;

  assign consume    = in_valid_q && free_i;
  assign in_stall_o = in_valid_q && !free_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    work.st = state_q;
    work.rn = 3'd0;
    work.r  = '0;
    unique case (state_q.phase)
      PH_DETECT: work = f_detect(work, in_item_q.in_byte);
      PH_UTF8:   work = f_utf8(work, in_item_q.in_byte);
      PH_UTF16:  work = f_utf16(work, in_item_q.in_byte);
      PH_DRAIN:  work = work;
    endcase
    if (in_item_q.end_of_stream && work.st.phase != PH_DRAIN) begin
      work = f_finish(work);
    end
  end

  always_comb begin
    state_d = state_q;
    if (consume) begin
      state_d = in_item_q.end_of_stream ? StateReset : work.st;
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (consume) begin
      in_valid_d = 1'b0;
    end
  end

  assign grp_o.load  = consume && (work.rn != 3'd0);
  assign grp_o.count = work.rn;
  assign grp_o.items = work.r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      state_q    <= StateReset;
    end else begin
      in_valid_q <= in_valid_d;
      state_q    <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_item_q <= in_item_i;
    end
  end

endmodule

@@ sv/b16u8_emit.sv @@
// Result group register that hands out the results of one byte, one per cycle while the output is not stalled.
`timescale 1ns / 1ps
module b16u8_emit
  import b16u8_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  grp_t      grp_i,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  output out_item_t out_item_o,
  output logic      free_o
);

  logic              valid_q, valid_d;
  logic [1:0]        idx_q, idx_d;
  logic [2:0]        count_q;
  res_t [MaxRes-1:0] items_q;
  res_t              cur;
  logic              last;
  logic              pop;

  assign cur    = items_q[idx_q];
  assign last   = (idx_q == 2'(count_q - 3'd1));
  assign pop    = valid_q && !out_stall_i;
  assign free_o = !valid_q || (pop && last);

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (grp_i.load) begin
      valid_d = 1'b1;
      idx_d   = 2'd0;
    end else if (pop && last) begin
      valid_d = 1'b0;
    end else if (pop) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (grp_i.load) begin
      count_q <= grp_i.count;
      items_q <= grp_i.items;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = '{out_byte: cur.out_byte, byte_valid: cur.byte_valid,
                         status: cur.status, detected_format: cur.detected_format,
                         run_last: last, stream_done: cur.stream_done};

endmodule

@@ sv/bom_sniffing_utf16_to_utf8_transcoder.sv @@
// Top level of the byte-order-mark sniffing UTF-16/UTF-8 to UTF-8 transcoder.
// Usage: raw stream bytes enter on the in channel, one request per byte, with
// end_of_stream set on the final byte. UTF-8 bytes and status results leave
// on the out channel, zero to four results per input byte, the last one of a
// byte flagged by run_last and the last one of a stream by stream_done.
// Each accepted byte waits in the input register until the result register
// is free, then its results are loaded there. The block takes one input byte
// per cycle while each byte gives at most one result and the out channel does
// not stall; a byte with several results holds the output until the single
// result port has passed them all. Bytes with no result (held mark bytes, first
// halves of UTF-16 units) pass as soon as the result register is free.
// A stall on the out channel holds the current result and, once the input
// register is full, raises the input stall in the same cycle.
// Reset clears both buffers and returns the decoder to encoding detection;
// the same state is taken up again after every end-of-stream byte.
`timescale 1ns / 1ps
module bom_sniffing_utf16_to_utf8_transcoder
  import b16u8_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  grp_t grp;
  logic free;

  b16u8_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_stall_o (in_stall_o),
    .free_i     (free),
    .grp_o      (grp)
  );

  b16u8_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grp_i       (grp),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .free_o      (free)
  );

endmodule

@@ sv/b16u8_checker.sv @@
// Port-level checks of the transcoder and their binding to the top level.
`timescale 1ns / 1ps
`include "bom_sniffing_utf16_to_utf8_transcoder_macros.svh"
module b16u8_checker
  import b16u8_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  logic in_req;
  logic out_hold;

  assign in_req   = in_valid_i && !in_stall_o && in_item_i.end_of_stream;
  assign out_hold = out_valid_o && out_stall_i;

  `B16U8_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_hold, out_valid_o && $stable(out_item_o))
  `B16U8_ASSERT_IMPL(a_status_only_ends, clk_i, rst_ni, out_valid_o && !out_item_o.byte_valid, out_item_o.run_last && out_item_o.stream_done)
  `B16U8_ASSERT_IMPL(a_data_ok, clk_i, rst_ni, out_valid_o && out_item_o.byte_valid, out_item_o.status == ST_OK)
  `B16U8_ASSERT_IMPL(a_done_last, clk_i, rst_ni, out_valid_o && out_item_o.stream_done, out_item_o.run_last)
  `B16U8_ASSERT_IMPL(a_no_bad_scalar, clk_i, rst_ni, out_valid_o || in_req, out_item_o.status != ST_BAD_SCALAR || !out_valid_o)

endmodule

bind bom_sniffing_utf16_to_utf8_transcoder b16u8_checker u_b16u8_checker (.*);

@@ tb/tb_bom_sniffing_utf16_to_utf8_transcoder.sv @@
// Self-checking testbench for the BOM-sniffing transcoder, with a built-in decoder model.
`timescale 1ns / 1ps
module tb_bom_sniffing_utf16_to_utf8_transcoder;
  import b16u8_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  phase_e          dec_phase;
  logic [2:0][7:0] mark_buf;
  int              mark_cnt;
  fmt_e            cur_fmt;
  int              cont_left;
  logic [20:0]     acc_cp;
  logic [1:0]      lead_cls;
  logic [7:0]      half_byte;
  logic            half_have;
  logic [9:0]      hi_bits;
  logic            hi_have;
  res_t            step_res [MaxRes];
  int              step_n;

  out_item_t expected_q[$];
  out_item_t oldest;
  int        errors;
  int        results_seen;
  int        bytes_sent;
  int        streams_sent;
  int        stall_left;
  bit        idle_on;

  bom_sniffing_utf16_to_utf8_transcoder i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  function automatic void decoder_clear();
    dec_phase = PH_DETECT;
    mark_buf  = '0;
    mark_cnt  = 0;
    cur_fmt   = FMT_UTF8;
    cont_left = 0;
    acc_cp    = '0;
    lead_cls  = CLS_TWO;
    half_byte = '0;
    half_have = 1'b0;
    hi_bits   = '0;
    hi_have   = 1'b0;
  endfunction

  function automatic void add_result(logic [7:0] b, logic v, status_e st, logic done);
    if (step_n < MaxRes) begin
      step_res[step_n].out_byte        = b;
      step_res[step_n].byte_valid      = v;
      step_res[step_n].status          = st;
      step_res[step_n].detected_format = cur_fmt;
      step_res[step_n].stream_done     = done;
      step_n++;
    end
  endfunction

  function automatic void stop_stream(status_e st);
    add_result(8'h00, 1'b0, st, 1'b1);
    dec_phase = PH_DRAIN;
  endfunction

  function automatic void utf8_fault();
    stop_stream(cur_fmt == FMT_UTF8_BOM ? ST_BAD_UTF8_BOM : ST_BAD_UTF8);
  endfunction

  function automatic void add_byte(ref byte_q_t s, input logic [7:0] b);
    s = {s, b};
  endfunction

  function automatic void put_utf8(ref byte_q_t s, input logic [20:0] cp);
    if (cp <= 21'h7f) begin
      add_byte(s, cp[7:0]);
    end else if (cp <= 21'h7ff) begin
      add_byte(s, {3'b110, cp[10:6]});
      add_byte(s, {2'b10, cp[5:0]});
    end else if (cp <= 21'hffff) begin
      add_byte(s, {4'b1110, cp[15:12]});
      add_byte(s, {2'b10, cp[11:6]});
      add_byte(s, {2'b10, cp[5:0]});
    end else begin
      add_byte(s, {5'b11110, cp[20:18]});
      add_byte(s, {2'b10, cp[17:12]});
      add_byte(s, {2'b10, cp[11:6]});
      add_byte(s, {2'b10, cp[5:0]});
    end
  endfunction

  function automatic void emit_scalar(logic [20:0] cp);
    byte_q_t enc;
    put_utf8(enc, cp);
    foreach (enc[i]) add_result(enc[i], 1'b1, ST_OK, 1'b0);
  endfunction

  function automatic void utf8_take(logic [7:0] b);
    logic [20:0] floor_cp;
    if (cont_left == 0) begin
      if (b <= 8'h7f) begin
        add_result(b, 1'b1, ST_OK, 1'b0);
        return;
      end
      if (b >= 8'hc2 && b <= 8'hdf) begin
        cont_left = 1;
        acc_cp    = {16'd0, b[4:0]};
        lead_cls  = CLS_TWO;
      end else if (b >= 8'he0 && b <= 8'hef) begin
        cont_left = 2;
        acc_cp    = {17'd0, b[3:0]};
        lead_cls  = CLS_THREE;
      end else if (b >= 8'hf0 && b <= 8'hf4) begin
        cont_left = 3;
        acc_cp    = {18'd0, b[2:0]};
        lead_cls  = CLS_FOUR;
      end else begin
        utf8_fault();
        return;
      end
      add_result(b, 1'b1, ST_OK, 1'b0);
      return;
    end
    if (b[7:6] != 2'b10) begin
      utf8_fault();
      return;
    end
    acc_cp = {acc_cp[14:0], b[5:0]};
    cont_left--;
    if (cont_left == 0) begin
      case (lead_cls)
        CLS_TWO:   floor_cp = 21'h80;
        CLS_THREE: floor_cp = 21'h800;
        default:   floor_cp = 21'h10000;
      endcase
      if (acc_cp < floor_cp || acc_cp > 21'h10ffff ||
          (acc_cp >= 21'hd800 && acc_cp <= 21'hdfff)) begin
        utf8_fault();
        return;
      end
    end
    add_result(b, 1'b1, ST_OK, 1'b0);
  endfunction

  function automatic void utf16_take(logic [7:0] b);
    logic [15:0] unit;
    if (!half_have) begin
      half_byte = b;
      half_have = 1'b1;
      return;
    end
    half_have = 1'b0;
    unit = (cur_fmt == FMT_UTF16LE) ? {b, half_byte} : {half_byte, b};
    if (hi_have) begin
      if (unit[15:10] != LO_SURR_TAG) begin
        stop_stream(ST_BAD_PAIR);
        return;
      end
      hi_have = 1'b0;
      emit_scalar(21'h10000 + {hi_bits, unit[9:0]});
      return;
    end
    if (unit[15:10] == HI_SURR_TAG) begin
      hi_bits = unit[9:0];
      hi_have = 1'b1;
    end else if (unit[15:10] == LO_SURR_TAG) begin
      stop_stream(ST_LONE_LOW);
    end else begin
      emit_scalar({5'd0, unit});
    end
  endfunction

  function automatic void replay_plain(logic [3:0][7:0] p, int k);
    cur_fmt   = FMT_UTF8;
    dec_phase = PH_UTF8;
    mark_cnt  = 0;
    for (int i = 0; i < k && dec_phase == PH_UTF8; i++) utf8_take(p[i]);
  endfunction

  function automatic void detect_take(logic [7:0] b);
    logic [3:0][7:0] p;
    logic [3:0][7:0] marks [4] = '{MARK_UTF8, MARK_U16BE, MARK_U32LE, MARK_U32BE};
    int              lens [4] = '{3, 2, 4, 4};
    int              k;
    bit              same;
    k = mark_cnt;
    p = {8'h00, mark_buf};
    p[k] = b;
    k++;
    if (k == 3 && p[2:0] == MARK_UTF8[2:0]) begin
      cur_fmt   = FMT_UTF8_BOM;
      dec_phase = PH_UTF8;
      mark_cnt  = 0;
      return;
    end
    if (k == 2 && p[1:0] == MARK_U16BE[1:0]) begin
      cur_fmt   = FMT_UTF16BE;
      dec_phase = PH_UTF16;
      mark_cnt  = 0;
      return;
    end
    if (k == 4 && (p == MARK_U32LE || p == MARK_U32BE)) begin
      mark_cnt = 0;
      stop_stream(ST_UTF32);
      return;
    end
    if (k >= 3 && p[0] == 8'hff && p[1] == 8'hfe && p[k-1] != 8'h00) begin
      cur_fmt   = FMT_UTF16LE;
      dec_phase = PH_UTF16;
      mark_cnt  = 0;
      if (k == 4) utf16_take(8'h00);
      utf16_take(p[k-1]);
      return;
    end
    for (int m = 0; m < 4; m++) begin
      if (k < lens[m]) begin
        same = 1'b1;
        for (int i = 0; i < k; i++) if (p[i] != marks[m][i]) same = 1'b0;
        if (same) begin
          mark_buf = p[2:0];
          mark_cnt = k;
          return;
        end
      end
    end
    replay_plain(p, k);
  endfunction

  function automatic void finish_stream();
    if (dec_phase == PH_DETECT) begin
      if (mark_cnt >= 2 && mark_buf[0] == 8'hff && mark_buf[1] == 8'hfe) begin
        cur_fmt   = FMT_UTF16LE;
        dec_phase = PH_UTF16;
        if (mark_cnt == 3) begin
          half_byte = mark_buf[2];
          half_have = 1'b1;
        end
        mark_cnt = 0;
      end else begin
        replay_plain({8'h00, mark_buf}, mark_cnt);
      end
    end
    if (dec_phase == PH_UTF8 && cont_left != 0) utf8_fault();
    if (dec_phase == PH_UTF16) begin
      if (half_have) stop_stream(ST_ODD_UTF16);
      else if (hi_have) stop_stream(ST_CUT_PAIR);
    end
    if (dec_phase != PH_DRAIN) begin
      if (step_n > 0 && step_res[step_n-1].byte_valid) step_res[step_n-1].stream_done = 1'b1;
      else add_result(8'h00, 1'b0, ST_OK, 1'b1);
    end
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic eos);
    out_item_t e;
    step_n = 0;
    case (dec_phase)
      PH_DETECT: detect_take(b);
      PH_UTF8:   utf8_take(b);
      PH_UTF16:  utf16_take(b);
      default:   ;
    endcase
    if (eos && dec_phase != PH_DRAIN) finish_stream();
    for (int i = 0; i < step_n; i++) begin
      e.out_byte        = step_res[i].out_byte;
      e.byte_valid      = step_res[i].byte_valid;
      e.status          = step_res[i].status;
      e.detected_format = step_res[i].detected_format;
      e.run_last        = (i == step_n - 1);
      e.stream_done     = step_res[i].stream_done;
      expected_q = {expected_q, e};
    end
    if (eos) decoder_clear();
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: out_byte 0x%0h status %0d",
               out_item_o.out_byte, out_item_o.status);
        errors++;
      end else begin
        oldest = expected_q.pop_front();
        check_field("out_byte", oldest.out_byte, out_item_o.out_byte);
        check_field("byte_valid", oldest.byte_valid, out_item_o.byte_valid);
        check_field("status", oldest.status, out_item_o.status);
        check_field("detected_format", oldest.detected_format, out_item_o.detected_format);
        check_field("run_last", oldest.run_last, out_item_o.run_last);
        check_field("stream_done", oldest.stream_done, out_item_o.stream_done);
      end
      results_seen++;
      stall_left = idle_on ? $urandom_range(0, 5) : 0;
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_byte(logic [7:0] b, logic eos);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= {b, eos};
    do @(posedge clk_i); while (in_stall_o);
    predict_byte(b, eos);
    bytes_sent++;
  endtask

  task automatic send_stream(byte_q_t s);
    if (s.size() == 0) add_byte(s, 8'h41);
    foreach (s[i]) send_byte(s[i], i == s.size() - 1);
    streams_sent++;
  endtask

  task automatic hold_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [20:0] pick_scalar();
    logic [20:0] cp;
    logic [20:0] bounds [10] = '{21'h0, 21'h7f, 21'h80, 21'h7ff, 21'h800, 21'hd7ff,
                                 21'he000, 21'hffff, 21'h10000, 21'h10ffff};
    case ($urandom_range(0, 4))
      0: cp = 21'($urandom_range(0, 'h7f));
      1: cp = 21'($urandom_range('h80, 'h7ff));
      2: begin
        cp = 21'($urandom_range('h800, 'hffff));
        if (cp >= 21'hd800 && cp <= 21'hdfff) cp = cp ^ 21'h4000;
      end
      3: cp = 21'($urandom_range('h10000, 'h10ffff));
      default: cp = bounds[$urandom_range(0, 9)];
    endcase
    return cp;
  endfunction

  function automatic void put_unit(ref byte_q_t s, input logic [15:0] u, input bit be);
    if (be) begin
      add_byte(s, u[15:8]);
      add_byte(s, u[7:0]);
    end else begin
      add_byte(s, u[7:0]);
      add_byte(s, u[15:8]);
    end
  endfunction

  function automatic void put_utf16(ref byte_q_t s, input logic [20:0] cp, input bit be);
    logic [19:0] v;
    if (cp >= 21'h10000) begin
      v = 20'(cp - 21'h10000);
      put_unit(s, {HI_SURR_TAG, v[19:10]}, be);
      put_unit(s, {LO_SURR_TAG, v[9:0]}, be);
    end else begin
      put_unit(s, cp[15:0], be);
    end
  endfunction

  function automatic void put_bad_utf8(ref byte_q_t s);
    case ($urandom_range(0, 9))
      0: begin add_byte(s, 8'hc0); add_byte(s, 8'h80); end
      1: begin add_byte(s, 8'hc1); add_byte(s, 8'hbf); end
      2: begin add_byte(s, 8'he0); add_byte(s, 8'h9f); add_byte(s, 8'hbf); end
      3: begin add_byte(s, 8'hed); add_byte(s, 8'ha0); add_byte(s, 8'h80); end
      4: begin
        add_byte(s, 8'hf0); add_byte(s, 8'h8f); add_byte(s, 8'hbf); add_byte(s, 8'hbf);
      end
      5: begin
        add_byte(s, 8'hf4); add_byte(s, 8'h90); add_byte(s, 8'h80); add_byte(s, 8'h80);
      end
      6: begin add_byte(s, 8'hf5); add_byte(s, 8'h80); end
      7: add_byte(s, 8'h80);
      8: begin add_byte(s, 8'hc2); add_byte(s, 8'h41); end
      default: add_byte(s, 8'hff);
    endcase
  endfunction

  task automatic test_utf32_mark();
    send_stream('{8'hff, 8'hfe, 8'h00, 8'h00});
  endtask

  task automatic test_utf16_surrogates();
    send_stream('{8'hff, 8'hfe, 8'h00, 8'hd8, 8'h00, 8'hdc, 8'h41, 8'h00});
    send_stream('{8'hfe, 8'hff, 8'hdb, 8'hff});
  endtask

  task automatic test_utf16_short_ends();
    send_stream('{8'hff, 8'hfe});
    send_stream('{8'hff, 8'hfe, 8'h00});
  endtask

  task automatic test_utf8_after_mark();
    send_stream('{8'hef, 8'hbb, 8'hbf, 8'hf4, 8'h90, 8'h80, 8'h80});
  endtask

  task automatic test_single_bytes();
    send_stream('{8'hff});
    send_stream('{8'h00});
  endtask

  task automatic test_random_utf16(int count);
    byte_q_t s;
    bit      be;
    int      n;
    int      stop_at;
    logic [15:0] u;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      idle_on = ($urandom_range(0, 3) != 0);
      s = {};
      be = $urandom_range(0, 1);
      put_unit(s, 16'hfeff, be);
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) put_utf16(s, pick_scalar(), be);
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: begin
            put_unit(s, {LO_SURR_TAG, 10'($urandom_range(0, 'h3ff))}, be);
            put_utf16(s, pick_scalar(), be);
          end
          1: begin
            put_unit(s, {HI_SURR_TAG, 10'($urandom_range(0, 'h3ff))}, be);
            u = 16'($urandom_range(0, 'hffff));
            if (u[15:10] == LO_SURR_TAG) u = u ^ 16'h2000;
            put_unit(s, u, be);
          end
          2: void'(s.pop_back());
          default: put_unit(s, {HI_SURR_TAG, 10'($urandom_range(0, 'h3ff))}, be);
        endcase
      end
      send_stream(s);
    end
  endtask

  task automatic test_random_utf8(int count);
    byte_q_t s;
    int      n;
    int      stop_at;
    bit      paused;
    stop_at = bytes_sent + count;
    paused = 1'b0;
    while (bytes_sent < stop_at) begin
      idle_on = ($urandom_range(0, 3) != 0);
      s = {};
      if ($urandom_range(0, 1)) begin
        add_byte(s, 8'hef);
        add_byte(s, 8'hbb);
        add_byte(s, 8'hbf);
      end
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) put_utf8(s, pick_scalar());
      if ($urandom_range(0, 3) == 0) begin
        put_bad_utf8(s);
        if ($urandom_range(0, 1)) put_utf8(s, pick_scalar());
      end else if ($urandom_range(0, 5) == 0 && s.size() > 1) begin
        void'(s.pop_back());
      end
      send_stream(s);
      if (!paused && bytes_sent >= stop_at - count / 2) begin
        hold_until_drained();
        paused = 1'b1;
      end
    end
  endtask

  task automatic test_random_noise(int count);
    byte_q_t s;
    int      n;
    int      stop_at;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      idle_on = ($urandom_range(0, 3) != 0);
      s = {};
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 7))
          0: add_byte(s, 8'h00);
          1: add_byte(s, 8'hff);
          2: add_byte(s, 8'hfe);
          3: add_byte(s, 8'hef);
          4: add_byte(s, 8'hbb);
          5: add_byte(s, 8'hbf);
          default: add_byte(s, 8'($urandom_range(0, 255)));
        endcase
      end
      send_stream(s);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_item_i    = '0;
    out_stall_i  = 1'b0;
    errors       = 0;
    results_seen = 0;
    bytes_sent   = 0;
    streams_sent = 0;
    stall_left   = 0;
    idle_on      = 1'b1;
    decoder_clear();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_utf32_mark();
    test_utf16_surrogates();
    test_utf16_short_ends();
    test_utf8_after_mark();
    test_single_bytes();
    test_random_utf16(170);
    test_random_utf8(170);
    test_random_noise(110);

    hold_until_drained();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d streams of %0d bytes in total and checked %0d results,",
             streams_sent, bytes_sent, results_seen);
    $display("covering mark detection, UTF-16 re-encoding and strict UTF-8 checking.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ bom_sniffing_utf16_to_utf8_transcoder.f @@
+incdir+sv
sv/b16u8_pkg.sv
sv/b16u8_core.sv
sv/b16u8_emit.sv
sv/bom_sniffing_utf16_to_utf8_transcoder.sv
sv/b16u8_checker.sv
tb/tb_bom_sniffing_utf16_to_utf8_transcoder.sv
